FILE: rtl/sam_pkg.sv
// Package: shared constants and types for the suffix automaton block.
package sam_pkg;

    localparam int MAX_TEXT_DEF       = 256;
    localparam int ALPHABET_DEF       = 256;
    localparam int QUERY_POS_BITS_DEF = 16;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_START,
        ST_A_WALK_RD,
        ST_A_WALK_CHK,
        ST_A_QLEN_RD,
        ST_A_QLEN_CHK,
        ST_A_COPY_RD,
        ST_A_COPY_WR,
        ST_A_REDIR_RD,
        ST_A_REDIR_CHK,
        ST_A_FIN_RD,
        ST_A_FIN,
        ST_Q_RD,
        ST_Q_CHK,
        ST_Q_LINK_RD,
        ST_Q_FIN,
        ST_OUT
    } seq_state_t;

endpackage

FILE: rtl/suffix_automaton_builder_matcher_unit.sv
// Top level: suffix automaton builder and query matcher with a sequencer.
//
//  channel  | direction | tdata fields (low bit first)                 | tuser
//  s_axis   | in        | symbol[7:0]                                  | func, query_start
//  m_axis   | out       | distinct_count, match_length, best_length,   | overflow
//           |           | best_end, contained                          |
//
// The work per word varies. An append runs the accept state, a set-up state, a read and a
// check per suffix-link step, then a finish without a clone (the finish alone, or after a
// length read and check), or for a clone a length read and check, a read and a write per
// entry of the copied row, a read and a check per redirected link and a last finish, then
// the output state. A query symbol runs the accept state, a lookup, check and length read
// per suffix link followed, a final lookup and check, the finish and the output state. After
// reset the transition memory is swept to zero, 2*MAX_TEXT rows of ALPHABET rounded up to a
// power of two (131072 entries by default), during which no word is accepted. One
// transition memory access a cycle sets the pace. A result register holds the finished word
// until m_axis_tready; the next word may run meanwhile and waits in ST_OUT while it is full.
module suffix_automaton_builder_matcher_unit #(
    parameter int MAX_TEXT       = sam_pkg::MAX_TEXT_DEF,
    parameter int ALPHABET       = sam_pkg::ALPHABET_DEF,
    parameter int QUERY_POS_BITS = sam_pkg::QUERY_POS_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // symbol[7:0]
    input  logic [1:0]  s_axis_tuser,   // func[0], query_start[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // distinct_count[15:0], match_length[24:16],
                                        // best_length[33:25], best_end[49:34],
                                        // contained[50], zero fill
    output logic        m_axis_tuser    // overflow
);
    localparam int NSTATES = 2 * MAX_TEXT;
    localparam int SB      = $clog2(NSTATES);
    localparam int AB      = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int LB      = $clog2(MAX_TEXT + 1);
    localparam int TB      = SB + AB;
    localparam int DEPTH   = NSTATES * (1 << AB);
    localparam logic [QUERY_POS_BITS-1:0] POS_MAX = '1;

    // Memories.
    logic [SB-1:0] trans_mem [DEPTH];
    logic [LB-1:0] len_mem   [NSTATES];
    logic [SB-1:0] link_mem  [NSTATES];

    logic [SB-1:0] tr_rd;
    logic [LB-1:0] len_rd;
    logic [SB-1:0] link_rd;

    // Control and data registers.
    sam_pkg::seq_state_t state_reg, state_next;
    logic [SB:0]   used_reg, used_next;
    logic [SB-1:0] last_reg, last_next;
    logic [LB-1:0] tlen_reg, tlen_next;
    logic [15:0]   total_reg, total_next;
    logic [SB-1:0] mst_reg, mst_next;
    logic [LB-1:0] mlen_reg, mlen_next;
    logic [LB-1:0] blen_reg, blen_next;
    logic [QUERY_POS_BITS-1:0] bpos_reg, bpos_next, qpos_reg, qpos_next;
    logic          cont_reg, cont_next;
    logic          ovf_reg, ovf_next;
    logic [TB-1:0] clr_reg, clr_next;
    logic          out_valid_reg, out_valid_next;
    logic [55:0]   out_data_reg, out_data_next;
    logic          out_user_reg, out_user_next;

    logic [7:0]    sym_reg, sym_next;
    logic [SB-1:0] p_reg, p_next, q_reg, q_next, cur_reg, cur_next;
    logic [SB-1:0] cl_reg, cl_next;
    logic [LB-1:0] plen_reg, plen_next, len_cur_reg, len_cur_next;
    logic [AB-1:0] col_reg, col_next;
    logic [SB-1:0] cval_reg, cval_next;

    // Memory port controls.
    logic          tr_we;
    logic [TB-1:0] tr_wa, tr_ra;
    logic [SB-1:0] tr_wd;
    logic          len_we, link_we;
    logic [SB-1:0] len_wa, len_ra, link_wa, link_ra;
    logic [LB-1:0] len_wd;
    logic [SB-1:0] link_wd;

    logic [55:0]   res_word;

    logic sym_ok;
    assign sym_ok = ({1'b0, sym_reg} < 9'(ALPHABET));

    function automatic logic [TB-1:0] taddr(input logic [SB-1:0] s, input logic [7:0] c);
        taddr = {s, c[AB-1:0]};
    endfunction

    // Result word built from the finished state.
    assign res_word = {5'd0, cont_reg,
                       (bpos_reg > QUERY_POS_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(bpos_reg),
                       9'(blen_reg), 9'(mlen_reg), total_reg};

    // Transition memory, single write and registered read.
    always_ff @(posedge clk)
    begin
        if (tr_we)
        begin
            trans_mem[tr_wa] <= tr_wd;
        end
        tr_rd <= trans_mem[tr_ra];
    end

    // State length and suffix link stores.
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_wa] <= len_wd;
        end
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        len_rd  <= len_mem[len_ra];
        link_rd <= link_mem[link_ra];
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sam_pkg::ST_CLEAR;
            used_reg      <= (SB+1)'(1);
            last_reg      <= '0;
            tlen_reg      <= '0;
            total_reg     <= 16'd1;
            mst_reg       <= '0;
            mlen_reg      <= '0;
            blen_reg      <= '0;
            bpos_reg      <= '0;
            qpos_reg      <= '0;
            cont_reg      <= 1'b1;
            ovf_reg       <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            last_reg      <= last_next;
            tlen_reg      <= tlen_next;
            total_reg     <= total_next;
            mst_reg       <= mst_next;
            mlen_reg      <= mlen_next;
            blen_reg      <= blen_next;
            bpos_reg      <= bpos_next;
            qpos_reg      <= qpos_next;
            cont_reg      <= cont_next;
            ovf_reg       <= ovf_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_user_reg  <= out_user_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        sym_reg     <= sym_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        cur_reg     <= cur_next;
        cl_reg      <= cl_next;
        plen_reg    <= plen_next;
        len_cur_reg <= len_cur_next;
        col_reg     <= col_next;
        cval_reg    <= cval_next;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        used_next = used_reg;   last_next = last_reg;   tlen_next = tlen_reg;
        total_next = total_reg; mst_next = mst_reg;     mlen_next = mlen_reg;
        blen_next = blen_reg;   bpos_next = bpos_reg;   qpos_next = qpos_reg;
        cont_next = cont_reg;   ovf_next = ovf_reg;     clr_next = clr_reg;
        sym_next = sym_reg;     p_next = p_reg;         q_next = q_reg;
        cur_next = cur_reg;     cl_next = cl_reg;       plen_next = plen_reg;
        len_cur_next = len_cur_reg; col_next = col_reg; cval_next = cval_reg;
        tr_we = 1'b0; tr_wa = '0; tr_wd = '0; tr_ra = taddr(p_reg, sym_reg);
        len_we = 1'b0; len_wa = '0; len_wd = '0; len_ra = p_reg;
        link_we = 1'b0; link_wa = '0; link_wd = '0; link_ra = p_reg;
        s_axis_tready = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sam_pkg::ST_CLEAR:
            begin
                tr_we = 1'b1; tr_wa = clr_reg; tr_wd = '0;
                len_we = 1'b1; len_wa = '0; len_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == TB'(DEPTH - 1))
                begin
                    state_next = sam_pkg::ST_IDLE;
                end
            end
            sam_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    sym_next = s_axis_tdata;
                    ovf_next = 1'b0;
                    if (!s_axis_tuser[0])
                    begin
                        if ({{(32-LB){1'b0}}, tlen_reg} >= MAX_TEXT
                            || {{(31-SB){1'b0}}, used_reg} + 32'd2 > NSTATES)
                        begin
                            ovf_next = 1'b1;
                            state_next = sam_pkg::ST_OUT;
                        end
                        else if ({1'b0, s_axis_tdata} >= 9'(ALPHABET))
                        begin
                            state_next = sam_pkg::ST_OUT;
                        end
                        else
                        begin
                            state_next = sam_pkg::ST_A_START;
                        end
                    end
                    else
                    begin
                        if (s_axis_tuser[1])
                        begin
                            mst_next = '0; mlen_next = '0; blen_next = '0;
                            bpos_next = '0; qpos_next = '0; cont_next = 1'b1;
                        end
                        state_next = sam_pkg::ST_Q_RD;
                    end
                end
            end
            // Append: create the new state with the length of last plus one.
            sam_pkg::ST_A_START:
            begin
                cur_next = used_reg[SB-1:0];
                used_next = used_reg + 1'b1;
                p_next = last_reg;
                len_ra = last_reg;
                state_next = sam_pkg::ST_A_WALK_RD;
            end
            sam_pkg::ST_A_WALK_RD:
            begin
                // len_rd holds len(last) on the first pass only.
                if (p_reg == last_reg)
                begin
                    len_cur_next = len_rd + 1'b1;
                    len_we = 1'b1; len_wa = cur_reg; len_wd = len_rd + 1'b1;
                end
                tr_ra = taddr(p_reg, sym_reg);
                link_ra = p_reg;
                len_ra = p_reg;
                state_next = sam_pkg::ST_A_WALK_CHK;
            end
            sam_pkg::ST_A_WALK_CHK:
            begin
                if (tr_rd != '0)
                begin
                    q_next = tr_rd;
                    plen_next = len_rd;
                    state_next = sam_pkg::ST_A_QLEN_RD;
                end
                else
                begin
                    tr_we = 1'b1; tr_wa = taddr(p_reg, sym_reg); tr_wd = cur_reg;
                    if (p_reg == '0)
                    begin
                        // Link to the root; a zero q marks the root link for the finish.
                        link_we = 1'b1; link_wa = cur_reg; link_wd = '0;
                        q_next = '0;
                        state_next = sam_pkg::ST_A_FIN_RD;
                    end
                    else
                    begin
                        p_next = link_rd;
                        state_next = sam_pkg::ST_A_WALK_RD;
                    end
                end
            end
            sam_pkg::ST_A_QLEN_RD:
            begin
                len_ra = q_reg;
                link_ra = q_reg;
                state_next = sam_pkg::ST_A_QLEN_CHK;
            end
            sam_pkg::ST_A_QLEN_CHK:
            begin
                if (plen_reg + 1'b1 == len_rd)
                begin
                    link_we = 1'b1; link_wa = cur_reg; link_wd = q_reg;
                    state_next = sam_pkg::ST_A_FIN_RD;
                end
                else
                begin
                    cl_next = used_reg[SB-1:0];
                    used_next = used_reg + 1'b1;
                    len_we = 1'b1; len_wa = used_reg[SB-1:0]; len_wd = plen_reg + 1'b1;
                    link_we = 1'b1; link_wa = used_reg[SB-1:0]; link_wd = link_rd;
                    col_next = '0;
                    state_next = sam_pkg::ST_A_COPY_RD;
                end
            end
            // Clone: copy the row of q, one entry per read and write.
            sam_pkg::ST_A_COPY_RD:
            begin
                tr_ra = {q_reg, col_reg};
                state_next = sam_pkg::ST_A_COPY_WR;
            end
            sam_pkg::ST_A_COPY_WR:
            begin
                tr_we = 1'b1; tr_wa = {cl_reg, col_reg}; tr_wd = tr_rd;
                col_next = col_reg + 1'b1;
                if (col_reg == AB'(ALPHABET - 1))
                begin
                    state_next = sam_pkg::ST_A_REDIR_RD;
                end
                else
                begin
                    state_next = sam_pkg::ST_A_COPY_RD;
                end
            end
            // Redirect transitions on c that point at q towards the clone.
            sam_pkg::ST_A_REDIR_RD:
            begin
                tr_ra = taddr(p_reg, sym_reg);
                link_ra = p_reg;
                state_next = sam_pkg::ST_A_REDIR_CHK;
            end
            sam_pkg::ST_A_REDIR_CHK:
            begin
                if (tr_rd == q_reg && p_reg != '0)
                begin
                    tr_we = 1'b1; tr_wa = taddr(p_reg, sym_reg); tr_wd = cl_reg;
                    p_next = link_rd;
                    state_next = sam_pkg::ST_A_REDIR_RD;
                end
                else
                begin
                    if (tr_rd == q_reg)
                    begin
                        tr_we = 1'b1; tr_wa = taddr(p_reg, sym_reg); tr_wd = cl_reg;
                    end
                    link_we = 1'b1; link_wa = q_reg; link_wd = cl_reg;
                    state_next = sam_pkg::ST_A_FIN;
                end
            end
            sam_pkg::ST_A_FIN:
            begin
                // Link of cur becomes the clone; len(clone) is plen + 1.
                link_we = 1'b1; link_wa = cur_reg; link_wd = cl_reg;
                total_next = total_reg + 16'(len_cur_reg) - 16'(plen_reg + 1'b1);
                last_next = cur_reg;
                tlen_next = tlen_reg + 1'b1;
                mst_next = '0; mlen_next = '0; blen_next = '0;
                bpos_next = '0; qpos_next = '0; cont_next = 1'b1;
                state_next = sam_pkg::ST_OUT;
            end
            sam_pkg::ST_A_FIN_RD:
            begin
                // Finish without a clone: the link is the root or q, with len(q) = plen + 1.
                total_next = total_reg + 16'(len_cur_reg)
                             - ((q_reg == '0) ? 16'd0 : 16'(plen_reg + 1'b1));
                last_next = cur_reg;
                tlen_next = tlen_reg + 1'b1;
                mst_next = '0; mlen_next = '0; blen_next = '0;
                bpos_next = '0; qpos_next = '0; cont_next = 1'b1;
                state_next = sam_pkg::ST_OUT;
            end
            // Query: look up the transition of the current match state.
            sam_pkg::ST_Q_RD:
            begin
                tr_ra = taddr(mst_reg, sym_reg);
                link_ra = mst_reg;
                state_next = sam_pkg::ST_Q_CHK;
            end
            sam_pkg::ST_Q_CHK:
            begin
                if (sym_ok && tr_rd != '0)
                begin
                    mst_next = tr_rd;
                    mlen_next = mlen_reg + 1'b1;
                    state_next = sam_pkg::ST_Q_FIN;
                end
                else
                begin
                    cont_next = 1'b0;
                    if (mst_reg == '0)
                    begin
                        state_next = sam_pkg::ST_Q_FIN;
                    end
                    else
                    begin
                        mst_next = link_rd;
                        len_ra = link_rd;
                        state_next = sam_pkg::ST_Q_LINK_RD;
                    end
                end
            end
            sam_pkg::ST_Q_LINK_RD:
            begin
                mlen_next = len_rd;
                state_next = sam_pkg::ST_Q_RD;
            end
            // Step the query position and keep the longest match.
            sam_pkg::ST_Q_FIN:
            begin
                if (qpos_reg != POS_MAX)
                begin
                    qpos_next = qpos_reg + 1'b1;
                end
                if (mlen_reg > blen_reg)
                begin
                    blen_next = mlen_reg;
                    bpos_next = qpos_reg;
                end
                state_next = sam_pkg::ST_OUT;
            end
            // Hand the word to the result register once it is free.
            sam_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = res_word;
                    out_user_next = ovf_reg;
                    state_next = sam_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sam_pkg::ST_IDLE;
            end
        endcase
    end

    // Output word.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tdata  = out_data_reg;

    // Result is held stable while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed while stalled");
    // Nothing moves on either side during the memory sweep.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sam_pkg::ST_CLEAR |-> !s_axis_tready && !m_axis_tvalid)
        else $error("handshake during memory sweep");
    // State count never exceeds capacity.
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        {{(31-SB){1'b0}}, used_reg} <= NSTATES)
        else $error("state store overrun");
endmodule
